[design/wti_pkg.sv]
`timescale 1ns / 1ps
package wti_pkg;

    localparam logic [1:0] MODE_SET   = 2'd0;
    localparam logic [1:0] MODE_DEL   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BEFORE = 2'd1;
    localparam logic [1:0] ST_AFTER  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam int DIV_DVD_W = 64;
    localparam int DIV_DSR_W = 32;

    typedef struct packed {
        logic [31:0]        time_key;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic signed [31:0] altitude;
    } entry_t;

endpackage

[design/waypoint_table_interpolator.sv]
`timescale 1ns / 1ps
// Sorted waypoint table with linear interpolation. Items are processed one at
// a time through a table memory of MAX_WAYPOINTS entries with one read and one
// write port (registered read). Every item first scans the table up to the
// first entry later than time_key. A set that inserts then shifts the tail up,
// and a delete shifts it down, one entry at a time. A query reads the two
// bracketing entries and runs each coordinate through a 32x32 multiply and a
// 64-step serial divider. Clear and out-of-range queries finish right after
// the scan. A result waits in an output register; the next item is taken while
// it waits.
module waypoint_table_interpolator #(
    parameter int MAX_WAYPOINTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [31:0]        time_key,
    input  logic signed [31:0] latitude_in,
    input  logic signed [31:0] longitude_in,
    input  logic signed [31:0] altitude_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] latitude_out,
    output logic signed [31:0] longitude_out,
    output logic signed [31:0] altitude_out
);
    import wti_pkg::*;

    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RD    = 5'd1;
    localparam logic [4:0] S_CMP   = 5'd2;
    localparam logic [4:0] S_DEC   = 5'd3;
    localparam logic [4:0] S_SH_RD = 5'd4;
    localparam logic [4:0] S_SH_WR = 5'd5;
    localparam logic [4:0] S_WR    = 5'd6;
    localparam logic [4:0] S_DL_RD = 5'd7;
    localparam logic [4:0] S_DL_WR = 5'd8;
    localparam logic [4:0] S_Q_RD0 = 5'd9;
    localparam logic [4:0] S_Q_RD1 = 5'd10;
    localparam logic [4:0] S_Q_LD  = 5'd11;
    localparam logic [4:0] S_MAG   = 5'd12;
    localparam logic [4:0] S_PROD  = 5'd13;
    localparam logic [4:0] S_DIV0  = 5'd14;
    localparam logic [4:0] S_DIV   = 5'd15;
    localparam logic [4:0] S_ADD   = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    localparam logic [1:0] COORD_LAT = 2'd0;
    localparam logic [1:0] COORD_LON = 2'd1;
    localparam logic [1:0] COORD_ALT = 2'd2;

    logic [4:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      j_reg;
    logic               eq_reg;
    logic [1:0]         mode_reg;
    entry_t             new_reg;
    entry_t             e0_reg;
    entry_t             e1_reg;
    entry_t             rdata_reg;
    logic [31:0]        num_reg;
    logic [31:0]        den_reg;
    logic [1:0]         coord_reg;
    logic signed [31:0] p0_reg;
    logic [31:0]        mag_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] lat_reg, lon_reg, alt_reg;
    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic signed [31:0] out_lat_reg, out_lon_reg, out_alt_reg;

    entry_t             entry_mem [MAX_WAYPOINTS];

    logic               mem_we;
    logic [CW-1:0]      mem_waddr;
    logic [CW-1:0]      mem_raddr;
    entry_t             mem_wdata;

    logic [CW-1:0]      idx_inc, idx_dec, j_inc, j_dec;
    logic               le;
    logic               out_load;
    logic signed [31:0] p0_sel, p1_sel;
    logic [32:0]        diff;
    logic [32:0]        diff_abs;
    logic signed [31:0] lerp_res;
    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic [31:0]        div_q;

    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);
    assign j_inc    = j_reg + CW'(1);
    assign j_dec    = j_reg - CW'(1);
    assign le       = rdata_reg.time_key <= new_reg.time_key;
    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = j_reg;
        mem_wdata = rdata_reg;
        unique case (state_reg)
            S_SH_RD: mem_raddr = j_dec;
            S_DL_RD: mem_raddr = j_inc;
            S_Q_RD0: mem_raddr = idx_dec;
            default: mem_raddr = idx_reg;
        endcase
        if (state_reg == S_SH_WR || state_reg == S_DL_WR)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_WR)
        begin
            mem_we    = 1'b1;
            mem_wdata = new_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        rdata_reg <= entry_mem[mem_raddr[AW-1:0]];
    end

    always_comb
    begin
        case (coord_reg)
            COORD_LAT:
            begin
                p0_sel = e0_reg.latitude;
                p1_sel = e1_reg.latitude;
            end
            COORD_LON:
            begin
                p0_sel = e0_reg.longitude;
                p1_sel = e1_reg.longitude;
            end
            default:
            begin
                p0_sel = e0_reg.altitude;
                p1_sel = e1_reg.altitude;
            end
        endcase
        diff     = {p1_sel[31], p1_sel} - {p0_sel[31], p0_sel};
        diff_abs = diff[32] ? (33'd0 - diff) : diff;
        lerp_res = neg_reg ? (p0_reg - $signed(div_q)) : (p0_reg + $signed(div_q));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (count_reg == '0) ? S_DEC : S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (le && idx_inc != count_reg)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (mode_reg)
                    MODE_SET:
                    begin
                        if (eq_reg)
                            state_next = S_WR;
                        else if (count_reg == CW'(MAX_WAYPOINTS))
                            state_next = S_DONE;
                        else if (count_reg == idx_reg)
                            state_next = S_WR;
                        else
                            state_next = S_SH_RD;
                    end
                    MODE_DEL:
                    begin
                        if (eq_reg && idx_reg != count_reg)
                            state_next = S_DL_RD;
                        else
                            state_next = S_DONE;
                    end
                    MODE_CLEAR:
                    begin
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        if (idx_reg == count_reg || idx_reg == '0)
                            state_next = S_DONE;
                        else
                            state_next = S_Q_RD0;
                    end
                endcase
            end
            S_SH_RD: state_next = S_SH_WR;
            S_SH_WR: state_next = (j_dec == idx_reg) ? S_WR : S_SH_RD;
            S_WR:    state_next = S_DONE;
            S_DL_RD: state_next = S_DL_WR;
            S_DL_WR: state_next = (j_inc + CW'(1) < count_reg) ? S_DL_RD : S_DONE;
            S_Q_RD0: state_next = S_Q_RD1;
            S_Q_RD1: state_next = S_Q_LD;
            S_Q_LD:  state_next = S_MAG;
            S_MAG:   state_next = S_PROD;
            S_PROD:  state_next = S_DIV0;
            S_DIV0:  state_next = S_DIV;
            S_DIV:   state_next = div_done ? S_ADD : S_DIV;
            S_ADD:   state_next = (coord_reg == COORD_ALT) ? S_DONE : S_MAG;
            S_DONE:  state_next = out_load ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DEC && mode_reg == MODE_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (state_reg == S_DEC && mode_reg == MODE_DEL && eq_reg
                     && idx_reg == count_reg)
            begin
                count_reg <= count_reg - CW'(1);
            end
            else if (state_reg == S_DL_WR && !(j_inc + CW'(1) < count_reg))
            begin
                count_reg <= count_reg - CW'(1);
            end
            else if (state_reg == S_WR && !eq_reg)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_reg   <= mode;
                    new_reg    <= {time_key, latitude_in, longitude_in, altitude_in};
                    idx_reg    <= '0;
                    eq_reg     <= 1'b0;
                    status_reg <= ST_OK;
                    lat_reg    <= '0;
                    lon_reg    <= '0;
                    alt_reg    <= '0;
                end
            end
            S_CMP:
            begin
                if (le)
                begin
                    idx_reg <= idx_inc;
                    eq_reg  <= (rdata_reg.time_key == new_reg.time_key);
                end
            end
            S_DEC:
            begin
                case (mode_reg)
                    MODE_SET:
                    begin
                        if (eq_reg)
                            j_reg <= idx_dec;
                        else if (count_reg == CW'(MAX_WAYPOINTS))
                            status_reg <= ST_FULL;
                        else
                            j_reg <= count_reg;
                    end
                    MODE_DEL:
                    begin
                        j_reg <= idx_dec;
                    end
                    MODE_QUERY:
                    begin
                        if (idx_reg == count_reg)
                            status_reg <= ST_AFTER;
                        else if (idx_reg == '0)
                            status_reg <= ST_BEFORE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SH_WR: j_reg <= j_dec;
            S_DL_WR: j_reg <= j_inc;
            S_Q_RD1: e0_reg <= rdata_reg;
            S_Q_LD:
            begin
                e1_reg    <= rdata_reg;
                num_reg   <= new_reg.time_key - e0_reg.time_key;
                den_reg   <= rdata_reg.time_key - e0_reg.time_key;
                coord_reg <= COORD_LAT;
            end
            S_MAG:
            begin
                p0_reg  <= p0_sel;
                neg_reg <= diff[32];
                mag_reg <= diff_abs[31:0];
            end
            S_PROD:
            begin
                prod_reg <= 64'(mag_reg) * 64'(num_reg);
            end
            S_ADD:
            begin
                case (coord_reg)
                    COORD_LAT: lat_reg <= lerp_res;
                    COORD_LON: lon_reg <= lerp_res;
                    default:   alt_reg <= lerp_res;
                endcase
                coord_reg <= coord_reg + 2'd1;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_lat_reg    <= lat_reg;
            out_lon_reg    <= lon_reg;
            out_alt_reg    <= alt_reg;
        end
    end

    assign div_start = (state_reg == S_DIV0);

    wti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign latitude_out  = out_lat_reg;
    assign longitude_out = out_lon_reg;
    assign altitude_out  = out_alt_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WAYPOINTS))
        else $error("entry count above table depth");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider running outside divide state");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised without finishing an item");

endmodule

[design/wti_div.sv]
`timescale 1ns / 1ps
module wti_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wti_pkg::DIV_DVD_W-1:0] dividend,
    input  logic [wti_pkg::DIV_DSR_W-1:0] divisor,
    output logic                          busy,
    output logic                          done,
    output logic [wti_pkg::DIV_DSR_W-1:0] quotient
);
    import wti_pkg::*;

    localparam int CNT_W = $clog2(DIV_DVD_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DVD_W-1:0] dvd_reg;
    logic [DIV_DSR_W-1:0] dsr_reg;
    logic [DIV_DSR_W-1:0] rem_reg;
    logic [DIV_DSR_W-1:0] quo_reg;
    logic [DIV_DSR_W:0]   trial;
    logic [DIV_DSR_W:0]   diff;
    logic                 take;

    assign trial = {rem_reg, dvd_reg[DIV_DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign take  = ~diff[DIV_DSR_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_DVD_W-2:0], 1'b0};
            rem_reg <= take ? diff[DIV_DSR_W-1:0] : trial[DIV_DSR_W-1:0];
            quo_reg <= {quo_reg[DIV_DSR_W-2:0], take};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[tb/tb_waypoint_table_interpolator.sv]
`timescale 1ns / 1ps
module tb_waypoint_table_interpolator;
    import wti_pkg::*;

    localparam int DEPTH = 64;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] alt;
    } position_t;

    class waypoint_scoreboard;
        logic [31:0]        wp_time[DEPTH];
        logic signed [31:0] wp_lat[DEPTH];
        logic signed [31:0] wp_lon[DEPTH];
        logic signed [31:0] wp_alt[DEPTH];
        int                 wp_count;
        position_t          pending[$];
        int                 errors;

        function new();
            wp_count = 0;
            errors = 0;
        endfunction

        function logic [31:0] blend(logic signed [31:0] p0, logic signed [31:0] p1,
                                    logic [31:0] num, logic [31:0] den);
            longint      d;
            logic [63:0] mag;
            logic [63:0] q;
            d = longint'(p1) - longint'(p0);
            mag = (d < 0) ? 64'(-d) : 64'(d);
            q = (mag * {32'd0, num}) / {32'd0, den};
            if (d < 0)
                return 32'(longint'(p0) - longint'(q));
            return 32'(longint'(p0) + longint'(q));
        endfunction

        function void note_item(logic [1:0] m, logic [31:0] t, logic signed [31:0] la,
                                logic signed [31:0] lo, logic signed [31:0] al);
            position_t r;
            int        pos;
            bit        found;
            r = '{ST_OK, 32'd0, 32'd0, 32'd0};
            pos = 0;
            while (pos < wp_count && wp_time[pos] <= t)
                pos++;
            found = pos > 0 && wp_time[pos-1] == t;
            case (m)
                MODE_SET:
                begin
                    if (!found && wp_count >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        if (!found)
                        begin
                            for (int i = wp_count; i > pos; i--)
                            begin
                                wp_time[i] = wp_time[i-1];
                                wp_lat[i] = wp_lat[i-1];
                                wp_lon[i] = wp_lon[i-1];
                                wp_alt[i] = wp_alt[i-1];
                            end
                            wp_count++;
                            pos++;
                        end
                        wp_time[pos-1] = t;
                        wp_lat[pos-1] = la;
                        wp_lon[pos-1] = lo;
                        wp_alt[pos-1] = al;
                    end
                end
                MODE_DEL:
                begin
                    if (found)
                    begin
                        for (int i = pos - 1; i + 1 < wp_count; i++)
                        begin
                            wp_time[i] = wp_time[i+1];
                            wp_lat[i] = wp_lat[i+1];
                            wp_lon[i] = wp_lon[i+1];
                            wp_alt[i] = wp_alt[i+1];
                        end
                        wp_count--;
                    end
                end
                MODE_CLEAR:
                    wp_count = 0;
                default:
                begin
                    if (pos >= wp_count)
                        r.status = ST_AFTER;
                    else if (pos == 0)
                        r.status = ST_BEFORE;
                    else
                    begin
                        r.lat = blend(wp_lat[pos-1], wp_lat[pos], t - wp_time[pos-1],
                                      wp_time[pos] - wp_time[pos-1]);
                        r.lon = blend(wp_lon[pos-1], wp_lon[pos], t - wp_time[pos-1],
                                      wp_time[pos] - wp_time[pos-1]);
                        r.alt = blend(wp_alt[pos-1], wp_alt[pos], t - wp_time[pos-1],
                                      wp_time[pos] - wp_time[pos-1]);
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] s, logic [31:0] la, logic [31:0] lo,
                                   logic [31:0] al);
            position_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result status=%0d", s);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (s !== e.status)
            begin
                $error("status expected %0d actual %0d", e.status, s);
                errors++;
            end
            if (la !== e.lat)
            begin
                $error("latitude_out expected %0d actual %0d", $signed(e.lat), $signed(la));
                errors++;
            end
            if (lo !== e.lon)
            begin
                $error("longitude_out expected %0d actual %0d", $signed(e.lon), $signed(lo));
                errors++;
            end
            if (al !== e.alt)
            begin
                $error("altitude_out expected %0d actual %0d", $signed(e.alt), $signed(al));
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         mode;
    logic [31:0]        time_key;
    logic signed [31:0] latitude_in;
    logic signed [31:0] longitude_in;
    logic signed [31:0] altitude_in;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic signed [31:0] latitude_out;
    logic signed [31:0] longitude_out;
    logic signed [31:0] altitude_out;

    waypoint_scoreboard track = new();
    bit                 feed_done;

    waypoint_table_interpolator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .time_key(time_key),
        .latitude_in(latitude_in), .longitude_in(longitude_in),
        .altitude_in(altitude_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .latitude_out(latitude_out),
        .longitude_out(longitude_out), .altitude_out(altitude_out)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic send_item(logic [1:0] m, logic [31:0] t, logic [31:0] la,
                             logic [31:0] lo, logic [31:0] al);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        time_key <= t;
        latitude_in <= la;
        longitude_in <= lo;
        altitude_in <= al;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track.note_item(m, t, la, lo, al);
    endtask

    function automatic logic [31:0] coord();
        case ($urandom_range(0, 5))
            0: return 32'(-1800000000);
            1: return 32'd1800000000;
            default: return 32'(int'($urandom_range(0, 3600000000)) - 1800000000);
        endcase
    endfunction

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(0, 4000);
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        mode = MODE_SET;
        time_key = '0;
        latitude_in = '0;
        longitude_in = '0;
        altitude_in = '0;
        feed_done = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_item(MODE_QUERY, 32'd5, 0, 0, 0);
        send_item(MODE_SET, 32'd0, 32'(-1800000000), 32'd1800000000, 32'h8000_0000);
        send_item(MODE_SET, 32'hFFFF_FFFF, 32'd1800000000, 32'(-1800000000), 32'h7FFF_FFFF);
        send_item(MODE_QUERY, 32'h8000_0000, 0, 0, 0);
        send_item(MODE_QUERY, 32'hFFFF_FFFE, 0, 0, 0);
        send_item(MODE_QUERY, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(MODE_SET, 32'd100, 32'd7, 32'(-7), 32'd3);
        send_item(MODE_QUERY, 32'd100, 0, 0, 0);
        send_item(MODE_QUERY, 32'd1, 0, 0, 0);
        send_item(MODE_SET, 32'd100, 32'd9, 32'(-9), 32'(-3));
        send_item(MODE_QUERY, 32'd50, 0, 0, 0);
        send_item(MODE_DEL, 32'd77, 0, 0, 0);
        send_item(MODE_DEL, 32'd0, 0, 0, 0);
        send_item(MODE_QUERY, 32'd0, 0, 0, 0);
        send_item(MODE_CLEAR, 32'd0, 0, 0, 0);
        send_item(MODE_QUERY, 32'd100, 0, 0, 0);
        for (int i = 0; i < DEPTH; i++)
            send_item(MODE_SET, 32'(i * 10 + 1), coord(), coord(), $urandom());
        send_item(MODE_SET, 32'd5, 1, 2, 3);
        send_item(MODE_SET, 32'd11, 4, 5, 6);
        send_item(MODE_QUERY, 32'd15, 0, 0, 0);
        send_item(MODE_CLEAR, 32'd0, 0, 0, 0);
        for (int n = 0; n < 520; n++)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 2)
                send_item(MODE_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
            else if (r < 40)
                send_item(MODE_SET, pick_time(), coord(), coord(), $urandom());
            else if (r < 52)
                send_item(MODE_DEL, pick_time(), $urandom(), $urandom(), $urandom());
            else
                send_item(MODE_QUERY, pick_time(), $urandom(), $urandom(), $urandom());
        end
        in_valid <= 1'b0;
        feed_done = 1'b1;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            track.check_result(status, latitude_out, longitude_out, altitude_out);
        end
    end

    initial
    begin
        wait (feed_done);
        while (track.pending.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        if (track.errors == 0)
            $display("tb_waypoint_table_interpolator: clean");
        else
            $display("tb_waypoint_table_interpolator: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_waypoint_table_interpolator: errors");
        $finish;
    end
endmodule
